// File: src/otd_pkg.sv
// Shared types, codes and helpers for the orientation and tap detector.
// No dependencies; imported by every module of the block.
package otd_pkg;

    localparam int AXIS_W  = 16;
    localparam int DET_W   = 15;
    localparam int CNT_W   = 8;
    localparam int ORI_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // orientation codes
    localparam logic [ORI_W-1:0] ORI_XP   = 3'd0;
    localparam logic [ORI_W-1:0] ORI_YP   = 3'd1;
    localparam logic [ORI_W-1:0] ORI_ZP   = 3'd2;
    localparam logic [ORI_W-1:0] ORI_XN   = 3'd3;
    localparam logic [ORI_W-1:0] ORI_YN   = 3'd4;
    localparam logic [ORI_W-1:0] ORI_ZN   = 3'd5;
    localparam logic [ORI_W-1:0] ORI_NONE = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_SMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_LIM  = 3'd4;

    // reset values
    localparam logic        [DET_W-1:0]  RST_DETECT_THR = 15'd3900;
    localparam logic signed [AXIS_W-1:0] RST_LEAVE_THR  = 16'sd2000;
    localparam logic signed [AXIS_W-1:0] RST_DIP_THR    = -16'sd500;
    localparam logic        [CNT_W-1:0]  RST_LEAVE_SMP  = 8'd4;
    localparam logic        [CNT_W-1:0]  RST_EVENT_LIM  = 8'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic        [DET_W-1:0]  detect_thr;
        logic signed [AXIS_W-1:0] leave_thr;
        logic signed [AXIS_W-1:0] dip_thr;
        logic        [CNT_W-1:0]  leave_smp;
        logic        [CNT_W-1:0]  event_lim;
    } t_cfg;

    typedef struct packed {
        logic [ORI_W-1:0] ori_now;
        logic             ori_lost;
        logic             det_ran;
        logic             tap_valid;
        logic [CNT_W-1:0] tap_len;
        logic [ORI_W-1:0] tap_ori;
    } t_result;

    // negation with -32768 saturating to +32767
    function automatic logic signed [AXIS_W-1:0] neg_sat(input logic signed [AXIS_W-1:0] v);
        logic signed [AXIS_W-1:0] res;
        if (v == {1'b1, {(AXIS_W-1){1'b0}}}) begin
            res = {1'b0, {(AXIS_W-1){1'b1}}};
        end else begin
            res = -v;
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] res;
        if (c == CNT_MAX) begin
            res = CNT_MAX;
        end else begin
            res = c + 1'b1;
        end
        return res;
    endfunction

endpackage

// File: src/otd_cfg_regs.sv
// Configuration register file of the orientation and tap detector.
// Depends on otd_pkg for register indexes, reset values and t_cfg.
module otd_cfg_regs import otd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_thr <= RST_DETECT_THR;
            r_cfg.leave_thr  <= RST_LEAVE_THR;
            r_cfg.dip_thr    <= RST_DIP_THR;
            r_cfg.leave_smp  <= RST_LEAVE_SMP;
            r_cfg.event_lim  <= RST_EVENT_LIM;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DETECT_THR: r_cfg.detect_thr <= i_cfg_data[DET_W-1:0];
                CFG_LEAVE_THR:  r_cfg.leave_thr  <= i_cfg_data;
                CFG_DIP_THR:    r_cfg.dip_thr    <= i_cfg_data;
                CFG_LEAVE_SMP:  r_cfg.leave_smp  <= i_cfg_data[CNT_W-1:0];
                CFG_EVENT_LIM:  r_cfg.event_lim  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/otd_core.sv
// Per-sample step: held orientation, low and dip run counters, tap report.
// Depends on otd_pkg; state advances when i_step is high.
module otd_core import otd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  t_cfg                     i_cfg,
    input  logic signed [AXIS_W-1:0] i_ax,
    input  logic signed [AXIS_W-1:0] i_ay,
    input  logic signed [AXIS_W-1:0] i_az,
    output t_result                  o_res
);

    logic [ORI_W-1:0] r_held, n_held;
    logic [CNT_W-1:0] r_low,  n_low;
    logic [CNT_W-1:0] r_dip,  n_dip;

    always_comb begin
        logic signed [AXIS_W-1:0] val;
        logic signed [AXIS_W:0]   thr_p;
        logic signed [AXIS_W:0]   thr_n;
        logic [CNT_W-1:0]         low_inc;
        logic [ORI_W-1:0]         ori;
        logic                     held;

        val     = '0;
        held    = 1'b1;
        ori     = r_held;
        n_low   = r_low;
        n_dip   = r_dip;
        o_res   = '0;
        o_res.tap_ori = ORI_NONE;

        case (r_held)
            ORI_XP:  val = i_ax;
            ORI_YP:  val = i_ay;
            ORI_ZP:  val = i_az;
            ORI_XN:  val = neg_sat(i_ax);
            ORI_YN:  val = neg_sat(i_ay);
            ORI_ZN:  val = neg_sat(i_az);
            default: held = 1'b0;
        endcase

        low_inc = inc_sat(r_low);

        if (held) begin
            if (val < i_cfg.leave_thr) begin
                n_low = low_inc;
                if (low_inc > i_cfg.leave_smp) begin
                    ori = ORI_NONE;
                    o_res.ori_lost = 1'b1;
                    n_low = '0;
                end
            end else begin
                n_low = '0;
            end

            if (val < i_cfg.dip_thr) begin
                n_dip = inc_sat(r_dip);
            end else begin
                if ((r_dip != '0) && (r_dip < i_cfg.event_lim)) begin
                    o_res.tap_valid = 1'b1;
                    o_res.tap_len   = r_dip;
                    o_res.tap_ori   = ori;
                end
                n_dip = '0;
            end
        end else begin
            ori = ORI_NONE;
        end

        // acquisition: X, Y, Z in turn, plus face before minus face
        thr_p = $signed({2'b00, i_cfg.detect_thr});
        thr_n = -thr_p;
        if (ori == ORI_NONE) begin
            if      ($signed({i_ax[AXIS_W-1], i_ax}) > thr_p) ori = ORI_XP;
            else if ($signed({i_ax[AXIS_W-1], i_ax}) < thr_n) ori = ORI_XN;
            else if ($signed({i_ay[AXIS_W-1], i_ay}) > thr_p) ori = ORI_YP;
            else if ($signed({i_ay[AXIS_W-1], i_ay}) < thr_n) ori = ORI_YN;
            else if ($signed({i_az[AXIS_W-1], i_az}) > thr_p) ori = ORI_ZP;
            else if ($signed({i_az[AXIS_W-1], i_az}) < thr_n) ori = ORI_ZN;
            o_res.det_ran = 1'b1;
            n_low = '0;
            n_dip = '0;
        end

        n_held        = ori;
        o_res.ori_now = ori;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= ORI_ZP;
            r_low  <= '0;
            r_dip  <= '0;
        end else if (i_step) begin
            r_held <= n_held;
            r_low  <= n_low;
            r_dip  <= n_dip;
        end
    end

endmodule

// File: src/orientation_tap_detector.sv
// Top level of the orientation and tap detector: input register, step, result register.
// Depends on otd_pkg, otd_cfg_regs and otd_core.
//
//   channel   valid         stall         payload
//   input     i_in_valid    o_in_stall    i_accel_x, i_accel_y, i_accel_z
//   result    o_out_valid   i_out_stall   o_orientation_now .. o_tap_orientation
//   config    i_cfg_wr_en   (none)        i_cfg_index, i_cfg_data
//
// One sample per cycle unless the result stalls; input register, then result register.
// The held orientation and run counters advance as a sample moves into the result register.
// Synchronous active-low reset: orientation Z+, counters zero, registers at defaults.
// A stalled result holds the pipe; o_in_stall rises only while both registers are full.
module orientation_tap_detector import otd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [AXIS_W-1:0] i_accel_x,
    input  logic signed [AXIS_W-1:0] i_accel_y,
    input  logic signed [AXIS_W-1:0] i_accel_z,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ORI_W-1:0]         o_orientation_now,
    output logic                     o_orientation_lost,
    output logic                     o_detection_ran,
    output logic                     o_tap_valid,
    output logic [CNT_W-1:0]         o_tap_length,
    output logic [ORI_W-1:0]         o_tap_orientation,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result res;

    logic                     r_in_valid;
    logic signed [AXIS_W-1:0] r_ax, r_ay, r_az;
    logic                     r_out_valid;
    t_result                  r_res;

    logic out_free, step, in_xfer;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    otd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    otd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_az    (r_az),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
        end
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_orientation_now  = r_res.ori_now;
    assign o_orientation_lost = r_res.ori_lost;
    assign o_detection_ran    = r_res.det_ran;
    assign o_tap_valid        = r_res.tap_valid;
    assign o_tap_length       = r_res.tap_len;
    assign o_tap_orientation  = r_res.tap_ori;

    a_tap_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tap_valid |-> o_tap_length != '0)
        else $error("tap reported with zero length");

    a_no_tap_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tap_valid |-> o_tap_length == '0 && o_tap_orientation == ORI_NONE)
        else $error("tap fields set without a tap");

    a_lost_runs_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_orientation_lost |-> o_detection_ran)
        else $error("orientation dropped without acquisition pass");

    a_held_not_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_detection_ran |-> o_orientation_now != ORI_NONE)
        else $error("no orientation held but acquisition skipped");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free stage");

endmodule

// File: tb/orientation_tap_detector_tb.sv
// Self-checking testbench for orientation_tap_detector: directed rows, then randomised runs.
// A local orientation/tap tracker predicts untyped results; depends on otd_pkg and the RTL.
module orientation_tap_detector_tb;
    import otd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int QUIET_LIMIT     = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef enum int {LVL_ABOVE, LVL_BETWEEN, LVL_BELOW} t_level;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic                     typed;
        t_result                  res;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [AXIS_W-1:0] i_accel_x = '0;
    logic signed [AXIS_W-1:0] i_accel_y = '0;
    logic signed [AXIS_W-1:0] i_accel_z = '0;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [ORI_W-1:0]         o_orientation_now;
    logic                     o_orientation_lost;
    logic                     o_detection_ran;
    logic                     o_tap_valid;
    logic [CNT_W-1:0]         o_tap_length;
    logic [ORI_W-1:0]         o_tap_orientation;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]     i_cfg_data = '0;

    // tracker copy of the registers and state
    int thr_detect, thr_leave, thr_dip, low_run_max, tap_len_limit;
    logic [ORI_W-1:0] held_face;
    int low_run, dip_run;

    t_result pending_reports[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    bit      hold_req = 1'b0;
    bit      long_runs = 1'b0;
    int      run_left = 0;
    t_level  run_kind = LVL_ABOVE;

    // held value -> lost after leave_samples+1 lows; dip run ending -> tap
    t_stim_row directed_rows [23] = '{
        '{16'sd0, 16'sd0, 16'sd16384, 1'b1, '{ORI_ZP, 1'b0, 1'b0, 1'b0, 8'd0, ORI_NONE}},
        '{16'sd0, 16'sd0, -16'sd1000, 1'b0, '0},
        '{16'sd0, 16'sd0, -16'sd1000, 1'b0, '0},
        '{16'sd0, 16'sd0, 16'sd16384, 1'b1, '{ORI_ZP, 1'b0, 1'b0, 1'b1, 8'd2, ORI_ZP}},
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ORI_ZP, 1'b0, 1'b0, 1'b0, 8'd0, ORI_NONE}},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ORI_NONE, 1'b1, 1'b1, 1'b0, 8'd0, ORI_NONE}},
        // X wins over Y when both are beyond the threshold
        '{16'sd32767, 16'sh8000, 16'sd0, 1'b1, '{ORI_XP, 1'b0, 1'b1, 1'b0, 8'd0, ORI_NONE}},
        '{16'sh8000, 16'sd32767, 16'sd32767, 1'b1,
          '{ORI_XP, 1'b0, 1'b0, 1'b0, 8'd0, ORI_NONE}},
        '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
        // drop, tap end and reacquire in the same transfer
        '{16'sd0, 16'sh8000, 16'sd0, 1'b1, '{ORI_YN, 1'b1, 1'b1, 1'b1, 8'd4, ORI_NONE}},
        // minus face: -32768 saturates to +32767
        '{16'sd0, 16'sh8000, 16'sd0, 1'b1, '{ORI_YN, 1'b0, 1'b0, 1'b0, 8'd0, ORI_NONE}},
        '{16'sd0, 16'sd32767, 16'sd0, 1'b1, '{ORI_YN, 1'b0, 1'b0, 1'b0, 8'd0, ORI_NONE}},
        '{16'sd0, 16'sh8000, 16'sd0, 1'b1, '{ORI_YN, 1'b0, 1'b0, 1'b1, 8'd1, ORI_YN}},
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ORI_YN, 1'b0, 1'b0, 1'b0, 8'd0, ORI_NONE}},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
        '{-16'sd4000, 16'sd5000, -16'sd5000, 1'b1,
          '{ORI_XN, 1'b1, 1'b1, 1'b0, 8'd0, ORI_NONE}}
    };

    orientation_tap_detector dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_accel_x          (i_accel_x),
        .i_accel_y          (i_accel_y),
        .i_accel_z          (i_accel_z),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_orientation_now  (o_orientation_now),
        .o_orientation_lost (o_orientation_lost),
        .o_detection_ran    (o_detection_ran),
        .o_tap_valid        (o_tap_valid),
        .o_tap_length       (o_tap_length),
        .o_tap_orientation  (o_tap_orientation),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // empty range falls back to a full-scale value
    function automatic int pick_range(input int lo, input int hi);
        if (lo > hi) begin
            return $urandom_range(0, 1) ? 32767 : -32768;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int face_axis(input logic [ORI_W-1:0] f);
        case (f) inside
            ORI_XP, ORI_XN: return 0;
            ORI_YP, ORI_YN: return 1;
            default: return 2;
        endcase
    endfunction

    function automatic bit face_negative(input logic [ORI_W-1:0] f);
        return (f == ORI_XN) || (f == ORI_YN) || (f == ORI_ZN);
    endfunction

    function automatic logic [ORI_W-1:0] axis_face(input int a, input bit neg);
        case (a)
            0: return neg ? ORI_XN : ORI_XP;
            1: return neg ? ORI_YN : ORI_YP;
            default: return neg ? ORI_ZN : ORI_ZP;
        endcase
    endfunction

    function automatic t_result track_sample(input logic signed [AXIS_W-1:0] sx, sy, sz);
        int ax[3];
        int val;
        int a;
        bit found;
        logic [ORI_W-1:0] face;
        t_result r;
        ax[0] = sx;
        ax[1] = sy;
        ax[2] = sz;
        face = held_face;
        r = '0;
        r.tap_ori = ORI_NONE;
        if (face != ORI_NONE) begin
            val = ax[face_axis(face)];
            if (face_negative(face)) begin
                val = (val == -32768) ? 32767 : -val;
            end
            if (val < thr_leave) begin
                if (low_run < CNT_MAX) low_run++;
                if (low_run > low_run_max) begin
                    face = ORI_NONE;
                    r.ori_lost = 1'b1;
                    low_run = 0;
                end
            end else begin
                low_run = 0;
            end
            if (val < thr_dip) begin
                if (dip_run < CNT_MAX) dip_run++;
            end else begin
                if (dip_run > 0 && dip_run < tap_len_limit) begin
                    r.tap_valid = 1'b1;
                    r.tap_len   = dip_run[CNT_W-1:0];
                    r.tap_ori   = face;
                end
                dip_run = 0;
            end
        end
        if (face == ORI_NONE) begin
            found = 1'b0;
            for (a = 0; a < 3; a++) begin
                if (!found && (ax[a] > thr_detect || ax[a] < -thr_detect)) begin
                    found = 1'b1;
                    face = axis_face(a, ax[a] < 0);
                end
            end
            r.det_ran = 1'b1;
            low_run = 0;
            dip_run = 0;
        end
        held_face = face;
        r.ori_now = face;
        return r;
    endfunction

    // mostly level runs on the held axis, or acquisition attempts when nothing is held
    function automatic void gen_sample(output logic signed [AXIS_W-1:0] sx, sy, sz);
        int ax[3];
        int a, sel, v, mag, lo_t, hi_t;
        for (a = 0; a < 3; a++) ax[a] = int'($urandom_range(0, 65535)) - 32768;
        if (run_left < 13 && $urandom_range(0, 9) == 0) begin
            // noise: keep the three random axes
        end else if (held_face == ORI_NONE) begin
            sel = $urandom_range(0, 2);
            for (a = 0; a < sel; a++) begin
                if ($urandom_range(0, 3) != 0) ax[a] = pick_range(-thr_detect, thr_detect);
            end
            case ($urandom_range(0, 3))
                0: mag = thr_detect;
                1: mag = thr_detect + 1;
                default: mag = pick_range(thr_detect + 1, 32768);
            endcase
            ax[sel] = clamp16($urandom_range(0, 1) ? -mag : mag);
        end else begin
            if (run_left == 0) begin
                run_kind = t_level'($urandom_range(0, 2));
                run_left = (long_runs && $urandom_range(0, 5) == 0) ?
                           $urandom_range(200, 300) : $urandom_range(1, 12);
            end
            run_left--;
            lo_t = (thr_leave < thr_dip) ? thr_leave : thr_dip;
            hi_t = (thr_leave < thr_dip) ? thr_dip : thr_leave;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 5))
                    0: v = thr_leave;
                    1: v = thr_leave - 1;
                    2: v = thr_dip;
                    3: v = thr_dip - 1;
                    4: v = -32768;
                    default: v = 32767;
                endcase
                v = clamp16(v);
            end else begin
                case (run_kind)
                    LVL_ABOVE: v = pick_range(hi_t, 32767);
                    LVL_BETWEEN: v = pick_range(lo_t, hi_t - 1);
                    default: v = pick_range(-32768, lo_t - 1);
                endcase
            end
            a = face_axis(held_face);
            if (face_negative(held_face)) begin
                ax[a] = (v == 32767 && $urandom_range(0, 1)) ? -32768 : clamp16(-v);
            end else begin
                ax[a] = v;
            end
        end
        sx = ax[0];
        sy = ax[1];
        sz = ax[2];
    endfunction

    task automatic send_sample(input logic signed [AXIS_W-1:0] sx, sy, sz,
                               input logic typed, input t_result typed_res);
        t_result pred;
        if (tx_idle_on && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_accel_x  <= sx;
        i_accel_y  <= sy;
        i_accel_z  <= sz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = track_sample(sx, sy, sz);
        pending_reports.push_back(typed ? typed_res : pred);
    endtask

    task automatic run_phase(input int n_items, input bit with_long_runs);
        logic signed [AXIS_W-1:0] sx, sy, sz;
        long_runs = with_long_runs;
        run_left = 0;
        repeat (n_items) begin
            gen_sample(sx, sy, sz);
            send_sample(sx, sy, sz, 1'b0, '0);
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_DETECT_THR: thr_detect    = int'(data[DET_W-1:0]);
            CFG_LEAVE_THR:  thr_leave     = int'($signed(data));
            CFG_DIP_THR:    thr_dip       = int'($signed(data));
            CFG_LEAVE_SMP:  low_run_max   = int'(data[CNT_W-1:0]);
            CFG_EVENT_LIM:  tap_len_limit = int'(data[CNT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input logic [CFG_DAT_W-1:0] detect, leave, dip,
                             input logic [CNT_W-1:0] lsmp, elim);
        write_reg(CFG_DETECT_THR, detect);
        write_reg(CFG_LEAVE_THR, leave);
        write_reg(CFG_DIP_THR, dip);
        write_reg(CFG_LEAVE_SMP, {8'd0, lsmp});
        write_reg(CFG_EVENT_LIM, {8'd0, elim});
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : out_stall_gen
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : report_check
        t_result exp_r;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_reports.size() == 0) begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end else begin
                exp_r = pending_reports.pop_front();
                check_field("orientation_now", exp_r.ori_now, o_orientation_now);
                check_field("orientation_lost", exp_r.ori_lost, o_orientation_lost);
                check_field("detection_ran", exp_r.det_ran, o_detection_ran);
                check_field("tap_valid", exp_r.tap_valid, o_tap_valid);
                check_field("tap_length", exp_r.tap_len, o_tap_length);
                check_field("tap_orientation", exp_r.tap_ori, o_tap_orientation);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("orientation_tap_detector_tb: FAIL");
            $finish;
        end
    end

    initial begin : main_seq
        int i;
        thr_detect    = int'(RST_DETECT_THR);
        thr_leave     = int'(RST_LEAVE_THR);
        thr_dip       = int'(RST_DIP_THR);
        low_run_max   = int'(RST_LEAVE_SMP);
        tap_len_limit = int'(RST_EVENT_LIM);
        held_face     = ORI_ZP;
        low_run       = 0;
        dip_run       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < $size(directed_rows); i++) begin
            send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                        directed_rows[i].typed, directed_rows[i].res);
        end

        // long receiver hold-off while samples keep coming, reset defaults
        hold_req = 1'b1;
        run_phase(120, 1'b0);
        drain();
        // acquire on any nonzero axis, drop at once, no dip and so no tap
        apply_cfg(16'd0, 16'sh7fff, 16'sh8000, 8'd0, 8'd255);
        run_phase(120, 1'b0);
        drain();
        // never drop, dip on nearly everything, no tap ever
        apply_cfg(16'h7fff, 16'sh8000, 16'sh7fff, 8'd255, 8'd0);
        run_phase(100, 1'b1);
        drain();
        // run counters saturate
        apply_cfg(16'd1000, 16'sd0, -16'sd2000, 8'd255, 8'd255);
        run_phase(250, 1'b1);
        drain();
        apply_cfg(16'd3900, 16'sd2000, -16'sd500, 8'd254, 8'd20);
        run_phase(200, 1'b1);
        drain();
        apply_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 20));
        run_phase(100, 1'b0);
        drain();
        // top data bit of detect threshold is dropped; unmapped index is ignored
        write_reg(CFG_NO_REG, 16'hffff);
        apply_cfg(16'h8000 | 16'd3900, 16'sd2000, -16'sd500, 8'd4, 8'd10);
        run_phase(80, 1'b0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_phase(80, 1'b0);
        drain();

        if (mismatches == 0) begin
            $display("orientation_tap_detector_tb: PASS");
        end else begin
            $display("orientation_tap_detector_tb: FAIL");
        end
        $finish;
    end

endmodule
